// ===== hw/rtl/ctim_pkg.sv =====
// ----------------------------------------------------------------------------
// ctim_pkg
// Shared types, constants and the quarter-wave sine image for the
// calibration tone injection mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package ctim_pkg;

    localparam int PHASE_BITS       = 20;
    localparam int SINE_TABLE_BITS  = 10;
    localparam int SAMPLE_RATE_LOG2 = 14;
    localparam int TAB_LEN          = 1 << SINE_TABLE_BITS;
    localparam int SINE_W           = 15;
    localparam int NUM_TONES        = 3;

    localparam int AMP_W      = 24;
    localparam int INC_W      = 19;
    localparam int START_W    = 32;
    localparam int SAMPLE_W   = 24;
    localparam int SUM_W      = 32;
    localparam int MIX_W      = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Only the low phase bits above the sample-rate shift survive the
    // start-offset product, since the rate is a power of two.
    localparam int LOAD_W   = PHASE_BITS - SAMPLE_RATE_LOG2;
    localparam int ADDR_LSB = PHASE_BITS - SINE_TABLE_BITS - 2;

    localparam int PROD_W      = AMP_W + SINE_W + 1;
    localparam int ROUND_SHIFT = 15;
    localparam int TONE_W      = PROD_W - ROUND_SHIFT;
    localparam int PAIR_W      = TONE_W + 1;
    localparam int PART_W      = SUM_W + 1;
    localparam int TOTAL_W     = PART_W + 1;

    localparam logic [INC_W-1:0] INC_LOW_RESET  = INC_W'(3347);
    localparam logic [INC_W-1:0] INC_MID_RESET  = INC_W'(10668);
    localparam logic [INC_W-1:0] INC_HIGH_RESET = INC_W'(59372);

    localparam logic signed [MIX_W-1:0] MIX_MAX = {1'b0, {(MIX_W-1){1'b1}}};
    localparam logic signed [MIX_W-1:0] MIX_MIN = {1'b1, {(MIX_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMP_LOW       = 3'd0,
        REG_AMP_MID       = 3'd1,
        REG_AMP_HIGH      = 3'd2,
        REG_INC_LOW       = 3'd3,
        REG_INC_MID       = 3'd4,
        REG_INC_HIGH      = 3'd5,
        REG_START_SECONDS = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] source_sample;
        logic                       sample_valid;
        logic                       end_of_time;
    } src_beat_t;

    typedef struct packed {
        logic signed [MIX_W-1:0] mix_sample;
        logic                    saturated;
    } mix_beat_t;

    typedef struct packed {
        logic [NUM_TONES-1:0][AMP_W-1:0] amp;
        logic [NUM_TONES-1:0][INC_W-1:0] inc;
        logic [START_W-1:0]              start;
    } cfg_t;

    // One closed sample slot on its way from the phase stage to the mixer.
    typedef struct packed {
        logic                             valid;
        logic [NUM_TONES-1:0]             neg;
        logic [NUM_TONES-1:0][SINE_W-1:0] mag;
        logic signed [SUM_W-1:0]          sum;
    } slot_t;

    // Restoring long division; evaluated only while the sine image is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine entry k in unsigned Q0.15, from a fixed-point Taylor series
    // in Q30; evaluated only while the sine image is built.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned n;
        longint unsigned scaled;
        longint          acc;
        x = (HALF_PI_Q30 * (longint'(k) * 2 + 1) + (64'd1 << SINE_TABLE_BITS))
            >> (SINE_TABLE_BITS + 1);
        x2 = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        acc = longint'(x);
        n = 1;
        for (int i = 0; i < 7; i++)
        begin
            term = div_u64((term * x2) >> 30, (n + 1) * (n + 2));
            n = n + 2;
            if (i[0])
                acc = acc + longint'(term);
            else
                acc = acc - longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (64'sd1 <<< 30))
            acc = 64'sd1 <<< 30;
        scaled = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
        return scaled[SINE_W-1:0];
    endfunction

    function automatic logic [TAB_LEN*SINE_W-1:0] build_sine_rom();
        logic [TAB_LEN*SINE_W-1:0] image;
        image = '0;
        for (int k = 0; k < TAB_LEN; k++)
        begin
            image[k*SINE_W +: SINE_W] = quarter_sine(k);
        end
        return image;
    endfunction

    localparam logic [TAB_LEN*SINE_W-1:0] SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/ctim_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ctim_cfg_regs
// Configuration register file: tone amplitudes, phase steps and the
// whole-second start offset.
// ----------------------------------------------------------------------------
`default_nettype none

module ctim_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [ctim_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctim_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ctim_pkg::cfg_t                          cfg,
    output logic                                    start_written
);

    ctim_pkg::cfg_t cfg_reg;
    ctim_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next      = cfg_reg;
        start_written = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                ctim_pkg::REG_AMP_LOW:
                    cfg_next.amp[0] = cfg_data[ctim_pkg::AMP_W-1:0];
                ctim_pkg::REG_AMP_MID:
                    cfg_next.amp[1] = cfg_data[ctim_pkg::AMP_W-1:0];
                ctim_pkg::REG_AMP_HIGH:
                    cfg_next.amp[2] = cfg_data[ctim_pkg::AMP_W-1:0];
                ctim_pkg::REG_INC_LOW:
                    cfg_next.inc[0] = cfg_data[ctim_pkg::INC_W-1:0];
                ctim_pkg::REG_INC_MID:
                    cfg_next.inc[1] = cfg_data[ctim_pkg::INC_W-1:0];
                ctim_pkg::REG_INC_HIGH:
                    cfg_next.inc[2] = cfg_data[ctim_pkg::INC_W-1:0];
                ctim_pkg::REG_START_SECONDS:
                begin
                    cfg_next.start = cfg_data[ctim_pkg::START_W-1:0];
                    start_written  = 1'b1;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amp    <= '0;
            cfg_reg.inc[0] <= ctim_pkg::INC_LOW_RESET;
            cfg_reg.inc[1] <= ctim_pkg::INC_MID_RESET;
            cfg_reg.inc[2] <= ctim_pkg::INC_HIGH_RESET;
            cfg_reg.start  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ctim_sine_rom.sv =====
// ----------------------------------------------------------------------------
// ctim_sine_rom
// Quarter-wave sine table with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctim_sine_rom (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic [ctim_pkg::SINE_TABLE_BITS-1:0]  addr,
    output logic [ctim_pkg::SINE_W-1:0]                data
);

    logic [ctim_pkg::SINE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= ctim_pkg::SINE_ROM[int'(addr) * ctim_pkg::SINE_W +: ctim_pkg::SINE_W];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ctim_front.sv =====
// ----------------------------------------------------------------------------
// ctim_front
// Input register, source accumulator and tone phase accumulators; issues
// the sine table reads for each closed sample slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ctim_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctim_pkg::cfg_t       cfg,
    input  wire logic                 start_written,
    input  wire logic                 src_valid,
    output logic                      src_stall,
    input  wire ctim_pkg::src_beat_t  src_data,
    input  wire logic                 slot_ready,
    output ctim_pkg::slot_t           slot
);

    localparam int PB = ctim_pkg::PHASE_BITS;
    localparam int NT = ctim_pkg::NUM_TONES;
    localparam int LW = ctim_pkg::LOAD_W;
    localparam int TB = ctim_pkg::SINE_TABLE_BITS;

    logic                       in_valid_reg;
    ctim_pkg::src_beat_t        in_beat_reg;
    logic signed [ctim_pkg::SUM_W-1:0] sum_reg;
    logic signed [ctim_pkg::SUM_W-1:0] sum_next;
    logic [NT-1:0][PB-1:0]      phase_reg;
    logic [NT-1:0][PB-1:0]      phase_next;
    logic                       loaded_reg;
    logic                       slot_valid_reg;
    logic [NT-1:0]              slot_neg_reg;
    logic signed [ctim_pkg::SUM_W-1:0] slot_sum_reg;

    logic                       fire;
    logic                       close_slot;
    logic                       in_ready;
    logic signed [ctim_pkg::SUM_W:0]   acc_wide;
    logic signed [ctim_pkg::SUM_W-1:0] acc_sat;
    logic [NT-1:0][2*LW-1:0]    load_prod;
    logic [NT-1:0][PB-1:0]      phase_use;
    logic [NT-1:0][TB-1:0]      rom_addr;
    logic [NT-1:0]              rom_neg;
    logic [NT-1:0][ctim_pkg::SINE_W-1:0] rom_mag;

    // A beat that does not close a slot only touches the accumulator, so it
    // never waits on the mixer.
    assign close_slot = in_valid_reg && in_beat_reg.end_of_time;
    assign fire       = in_valid_reg && (!in_beat_reg.end_of_time || slot_ready);
    assign in_ready   = !in_valid_reg || fire;
    assign src_stall  = !in_ready;

    always_comb
    begin
        acc_wide = (ctim_pkg::SUM_W+1)'(sum_reg)
                 + (ctim_pkg::SUM_W+1)'(in_beat_reg.source_sample);
        if (!in_beat_reg.sample_valid)
            acc_sat = sum_reg;
        else if (acc_wide[ctim_pkg::SUM_W] != acc_wide[ctim_pkg::SUM_W-1])
            acc_sat = acc_wide[ctim_pkg::SUM_W] ? ctim_pkg::SUM_MIN : ctim_pkg::SUM_MAX;
        else
            acc_sat = acc_wide[ctim_pkg::SUM_W-1:0];
        sum_next = in_beat_reg.end_of_time ? '0 : acc_sat;
    end

    always_comb
    begin
        for (int t = 0; t < NT; t++)
        begin
            load_prod[t] = cfg.inc[t][LW-1:0] * cfg.start[LW-1:0];
            phase_use[t] = loaded_reg ? phase_reg[t]
                         : {load_prod[t][LW-1:0], {ctim_pkg::SAMPLE_RATE_LOG2{1'b0}}};
            phase_next[t] = phase_use[t] + PB'(cfg.inc[t]);
            // Odd quadrants walk the table backwards; the upper half negates.
            rom_neg[t]  = phase_use[t][PB-1];
            rom_addr[t] = phase_use[t][PB-2] ? ~phase_use[t][ctim_pkg::ADDR_LSB +: TB]
                                             : phase_use[t][ctim_pkg::ADDR_LSB +: TB];
        end
    end

    for (genvar g = 0; g < NT; g++)
    begin : g_rom
        ctim_sine_rom u_rom (
            .clk  (clk),
            .en   (slot_ready),
            .addr (rom_addr[g]),
            .data (rom_mag[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            sum_reg        <= '0;
            phase_reg      <= '0;
            loaded_reg     <= 1'b0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= src_valid;
            if (fire)
                sum_reg <= sum_next;
            if (fire && close_slot)
                phase_reg <= phase_next;
            if (start_written)
                loaded_reg <= 1'b0;
            else if (fire && close_slot)
                loaded_reg <= 1'b1;
            if (slot_ready)
                slot_valid_reg <= fire && close_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && in_ready)
            in_beat_reg <= src_data;
        if (slot_ready)
        begin
            slot_neg_reg <= rom_neg;
            slot_sum_reg <= acc_sat;
        end
    end

    always_comb
    begin
        slot.valid = slot_valid_reg;
        slot.neg   = slot_neg_reg;
        slot.mag   = rom_mag;
        slot.sum   = slot_sum_reg;
    end

    // Closing a slot always leaves the accumulator empty.
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && close_slot) |=> (sum_reg == '0))
        else $error("source sum not cleared after a closed slot");

    // Phases stay loaded after a closed slot unless the offset is rewritten.
    a_phase_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && close_slot && !start_written) |=> loaded_reg)
        else $error("phases not marked loaded after a closed slot");

endmodule

`default_nettype wire

// ===== hw/rtl/ctim_mixer.sv =====
// ----------------------------------------------------------------------------
// ctim_mixer
// Tone products, rounding, summation with the source sum and output
// clipping, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctim_mixer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctim_pkg::cfg_t       cfg,
    input  wire ctim_pkg::slot_t      slot,
    output logic                      slot_ready,
    output logic                      mix_valid,
    input  wire logic                 mix_stall,
    output ctim_pkg::mix_beat_t       mix_data
);

    localparam int NT = ctim_pkg::NUM_TONES;
    localparam int PW = ctim_pkg::PROD_W;

    logic                            prod_valid_reg;
    logic signed [PW-1:0]            prod_reg [NT];
    logic signed [ctim_pkg::SUM_W-1:0] prod_sum_reg;
    logic                            part_valid_reg;
    logic signed [ctim_pkg::PAIR_W-1:0] pair_reg;
    logic signed [ctim_pkg::PART_W-1:0] part_reg;
    logic                            mix_valid_reg;
    ctim_pkg::mix_beat_t             mix_beat_reg;
    ctim_pkg::mix_beat_t             mix_beat_next;

    logic                            prod_ready;
    logic                            part_ready;
    logic                            out_ready;
    logic signed [ctim_pkg::SINE_W:0] sine [NT];
    logic signed [PW-1:0]            prod_next [NT];
    logic signed [PW-1:0]            biased [NT];
    logic signed [ctim_pkg::TONE_W-1:0] tone [NT];
    logic signed [ctim_pkg::TOTAL_W-1:0] total;

    assign out_ready  = !mix_valid_reg || !mix_stall;
    assign part_ready = !part_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || part_ready;
    assign slot_ready = !slot.valid || prod_ready;

    always_comb
    begin
        for (int t = 0; t < NT; t++)
        begin
            sine[t] = slot.neg[t] ? -$signed({1'b0, slot.mag[t]})
                                  : $signed({1'b0, slot.mag[t]});
            prod_next[t] = $signed(cfg.amp[t]) * sine[t];
            // Round half up to Q.0: floor((p + 2^14) / 2^15).
            biased[t] = prod_reg[t] + PW'(1 << (ctim_pkg::ROUND_SHIFT - 1));
            tone[t]   = $signed(biased[t][PW-1:ctim_pkg::ROUND_SHIFT]);
        end
    end

    always_comb
    begin
        total = ctim_pkg::TOTAL_W'(pair_reg) + ctim_pkg::TOTAL_W'(part_reg);
        if (total > ctim_pkg::TOTAL_W'(ctim_pkg::MIX_MAX))
        begin
            mix_beat_next.mix_sample = ctim_pkg::MIX_MAX;
            mix_beat_next.saturated  = 1'b1;
        end
        else if (total < ctim_pkg::TOTAL_W'(ctim_pkg::MIX_MIN))
        begin
            mix_beat_next.mix_sample = ctim_pkg::MIX_MIN;
            mix_beat_next.saturated  = 1'b1;
        end
        else
        begin
            mix_beat_next.mix_sample = total[ctim_pkg::MIX_W-1:0];
            mix_beat_next.saturated  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            part_valid_reg <= 1'b0;
            mix_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
                prod_valid_reg <= slot.valid;
            if (part_ready)
                part_valid_reg <= prod_valid_reg;
            if (out_ready)
                mix_valid_reg <= part_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready)
        begin
            for (int t = 0; t < NT; t++)
            begin
                prod_reg[t] <= prod_next[t];
            end
            prod_sum_reg <= slot.sum;
        end
        if (part_ready)
        begin
            pair_reg <= ctim_pkg::PAIR_W'(tone[0]) + ctim_pkg::PAIR_W'(tone[1]);
            part_reg <= ctim_pkg::PART_W'(tone[2]) + ctim_pkg::PART_W'(prod_sum_reg);
        end
        if (out_ready)
            mix_beat_reg <= mix_beat_next;
    end

    assign mix_valid = mix_valid_reg;
    assign mix_data  = mix_beat_reg;

    // A clipped beat carries one of the two range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (mix_valid_reg && mix_beat_reg.saturated) |->
        (mix_beat_reg.mix_sample == ctim_pkg::MIX_MAX ||
         mix_beat_reg.mix_sample == ctim_pkg::MIX_MIN))
        else $error("saturated beat not at a range limit");

    // Partial sums wait in place while the output register is blocked.
    a_part_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (part_valid_reg && !out_ready) |=> (part_valid_reg && $stable(part_reg)
                                            && $stable(pair_reg)))
        else $error("partial sums lost while output blocked");

endmodule

`default_nettype wire

// ===== hw/rtl/calibration_tone_injection_mixer_top.sv =====
// A closing beat reaches mix_valid through the table read, product, sum and output registers.
// Throughput: one source beat per cycle; closing beats too, unless mix_stall holds them.
// The rate is set by the five-register pipeline: input, sine table read, product, sum, output.
// Reset (rst_n, async, active low) clears the accumulator, phases and valid flags and
// restores the default tone steps; no clearing pass is needed.
// ----------------------------------------------------------------------------
// calibration_tone_injection_mixer_top
// Sums source samples per sample time and adds three calibration sine tones,
// emitting one saturated mixed sample per closed slot.
// ----------------------------------------------------------------------------
`default_nettype none

module calibration_tone_injection_mixer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [ctim_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ctim_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             src_valid,
    output logic                                  src_stall,
    input  wire ctim_pkg::src_beat_t              src_data,
    output logic                                  mix_valid,
    input  wire logic                             mix_stall,
    output ctim_pkg::mix_beat_t                   mix_data
);

    ctim_pkg::cfg_t  cfg;
    logic            start_written;
    ctim_pkg::slot_t slot;
    logic            slot_ready;

    ctim_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg           (cfg),
        .start_written (start_written)
    );

    ctim_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .start_written (start_written),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_data      (src_data),
        .slot_ready    (slot_ready),
        .slot          (slot)
    );

    ctim_mixer u_mixer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .slot       (slot),
        .slot_ready (slot_ready),
        .mix_valid  (mix_valid),
        .mix_stall  (mix_stall),
        .mix_data   (mix_data)
    );

endmodule

`default_nettype wire
